// ----- sv/erg_pkg.sv -----
// Shared types, constants and helpers for the Euclidean rhythm generator.
// No dependencies; every other file of the block imports this package.
package erg_pkg;

  localparam int STEP_W        = 5;
  localparam int PATTERN_W     = 16;
  localparam int MAX_STEPS_DEF = 16;
  localparam int RLEN_W        = $clog2(PATTERN_W + (1 << STEP_W));

  // Controller to datapath commands, at most one active per cycle.
  typedef struct packed {
    logic load;
    logic pair;
    logic cat_x;
    logic cat_y;
    logic emit;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic pair_last;
    logic x_empty;
    logic y_empty;
  } status_t;

  // Ones in the steps below len, zeros above.
  function automatic logic [PATTERN_W-1:0] len_mask(input logic [STEP_W-1:0] len);
    logic [PATTERN_W-1:0] m;
    m = '0;
    for (int i = 0; i < PATTERN_W; i++) begin
      m[i] = (i < int'(len));
    end
    return m;
  endfunction

endpackage

// ----- sv/euclidean_rhythm_generator.sv -----
// Euclidean rhythm generator: turns a beat count and a step count into one
// pattern word with the beats spread as evenly as possible over the steps.
// Step counts above MAX_STEPS saturate to MAX_STEPS; beat counts above the step
// count clamp to it; zero steps gives length 0 and an all-zero pattern. Bit i of
// pattern is step i (first step in the LSB); steps from 16 up are not returned.
// One item at a time: the block takes an item, holds req_stall high while it
// works, and frees up as soon as the result sits in the output register, so the
// next item may enter while that result still waits on rsp_stall. An item passes
// through a load step, the pairing rounds (1 to 7 rounds with the default
// MAX_STEPS of 16, set by the subtractive pairing loop; more for a larger bound),
// one step per copy appended by the shift-and-OR appender (at most 16 copies
// reach the word), a closing step for each of the two append passes and an emit
// step; an item takes longest when every step is a copy of its own (no beats, or
// every step a beat, over 16 steps). A result still stalled at the output adds
// its stall cycles to the emit step of the following item.
// Depends on erg_pkg, erg_ctrl and erg_dpath.
module euclidean_rhythm_generator #(
  parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [erg_pkg::STEP_W-1:0]    beat_count,
  input  logic [erg_pkg::STEP_W-1:0]    step_count,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [erg_pkg::PATTERN_W-1:0] pattern,
  output logic [erg_pkg::STEP_W-1:0]    pattern_length
);
  import erg_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencing: load, pair until a count drops to one, append, emit
  erg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .st        (st)
  );

  // pairing registers, appender and the output register
  erg_dpath #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dpath (
    .clk            (clk),
    .cmd            (cmd),
    .st             (st),
    .beat_count     (beat_count),
    .step_count     (step_count),
    .pattern        (pattern),
    .pattern_length (pattern_length)
  );

  // no onset beyond the pattern length
  a_tail_clear: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((pattern & ~len_mask(pattern_length)) == '0))
    else $error("pattern has onsets past pattern_length");

  // the length never exceeds the saturation bound
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (int'(pattern_length) <= MAX_STEPS))
    else $error("pattern_length above MAX_STEPS");

  // an item in flight keeps the input side closed
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("input opened again straight after accepting an item");

  // a result is loaded only from the emit step, never over an unread one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!rsp_valid || !rsp_stall))
    else $error("result overwritten while still stalled");

endmodule

// ----- sv/erg_ctrl.sv -----
// Sequencing state machine for the Euclidean rhythm generator.
// Depends on erg_pkg for the command and status structs.
module erg_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output erg_pkg::cmd_t    cmd,
  input  erg_pkg::status_t st
);
  import erg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAIR = 3'd1;
  localparam logic [2:0] S_CATX = 3'd2;
  localparam logic [2:0] S_CATY = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       rsp_valid_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PAIR;
        end
      end
      S_PAIR: begin
        cmd.pair = 1'b1;
        if (st.pair_last) begin
          state_next = S_CATX;
        end
      end
      S_CATX: begin
        if (st.x_empty) begin
          state_next = S_CATY;
        end else begin
          cmd.cat_x = 1'b1;
        end
      end
      S_CATY: begin
        if (st.y_empty) begin
          state_next = S_EMIT;
        end else begin
          cmd.cat_y = 1'b1;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!rsp_valid || !rsp_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// ----- sv/erg_dpath.sv -----
// Datapath of the Euclidean rhythm generator: pairing registers, appender and
// output register. Depends on erg_pkg for widths, structs and the length mask.
module erg_dpath #(
  parameter int MAX_STEPS = erg_pkg::MAX_STEPS_DEF
) (
  input  logic                             clk,
  input  erg_pkg::cmd_t                    cmd,
  output erg_pkg::status_t                 st,
  input  logic [erg_pkg::STEP_W-1:0]       beat_count,
  input  logic [erg_pkg::STEP_W-1:0]       step_count,
  output logic [erg_pkg::PATTERN_W-1:0]    pattern,
  output logic [erg_pkg::STEP_W-1:0]       pattern_length
);
  import erg_pkg::*;

  localparam int CMP_W = $clog2(MAX_STEPS + 1) > STEP_W ? $clog2(MAX_STEPS + 1) : STEP_W;

  logic [PATTERN_W-1:0] x_bits, y_bits, r_bits;
  logic [STEP_W-1:0]    x_len, y_len, xa, ya, steps;
  logic [RLEN_W-1:0]    r_len;

  logic [STEP_W-1:0]    steps_c, beats_c, xa_next, ya_next;
  logic                 x_wins;

  // saturate the step count, then clamp beats to it
  always_comb begin
    if (CMP_W'(step_count) > CMP_W'(MAX_STEPS)) begin
      steps_c = STEP_W'(MAX_STEPS);
    end else begin
      steps_c = step_count;
    end
    beats_c = (beat_count > steps_c) ? steps_c : beat_count;
  end

  // one pairing round
  assign x_wins  = (xa >= ya);
  assign xa_next = x_wins ? ya : xa;
  assign ya_next = x_wins ? (xa - ya) : (ya - xa);

  assign st.pair_last = (xa_next <= STEP_W'(1)) || (ya_next <= STEP_W'(1));
  // copies that would start past the word drop out
  assign st.x_empty   = (xa == '0) || (r_len >= RLEN_W'(PATTERN_W));
  assign st.y_empty   = (ya == '0) || (r_len >= RLEN_W'(PATTERN_W));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_bits <= PATTERN_W'(1);
      x_len  <= STEP_W'(1);
      y_bits <= '0;
      y_len  <= STEP_W'(1);
      xa     <= beats_c;
      ya     <= steps_c - beats_c;
      steps  <= steps_c;
      r_bits <= '0;
      r_len  <= '0;
    end else if (cmd.pair) begin
      xa     <= xa_next;
      ya     <= ya_next;
      x_bits <= x_bits | (y_bits << x_len);
      x_len  <= x_len + y_len;
      if (x_wins) begin
        y_bits <= x_bits;
        y_len  <= x_len;
      end
    end else if (cmd.cat_x) begin
      r_bits <= r_bits | (x_bits << r_len);
      r_len  <= r_len + RLEN_W'(x_len);
      xa     <= xa - STEP_W'(1);
    end else if (cmd.cat_y) begin
      r_bits <= r_bits | (y_bits << r_len);
      r_len  <= r_len + RLEN_W'(y_len);
      ya     <= ya - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pattern        <= r_bits & len_mask(steps);
      pattern_length <= steps;
    end
  end

endmodule

// ----- dv/rhythm_sb_pkg.sv -----
// Expected-rhythm predictor and scoreboard for the Euclidean rhythm generator bench.
// Depends on erg_pkg for field widths and the default step limit.
package rhythm_sb_pkg;

  import erg_pkg::*;

  localparam int unsigned STEP_LIMIT = MAX_STEPS_DEF;

  // One expected result, with the request that caused it kept for messages.
  typedef struct {
    logic [PATTERN_W-1:0] pattern;
    logic [STEP_W-1:0]    length;
    logic [STEP_W-1:0]    req_beats;
    logic [STEP_W-1:0]    req_steps;
  } rhythm_t;

  // A run of steps, first step in bit 0.
  typedef struct {
    logic [63:0] bits;
    int unsigned len;
  } step_run_t;

  function automatic step_run_t join_runs(step_run_t head, step_run_t tail);
    step_run_t r;
    r.bits = head.bits;
    if (head.len < 64) r.bits |= tail.bits << head.len;
    r.len = head.len + tail.len;
    if (r.len > 128) r.len = 128;
    return r;
  endfunction

  // Pair the onset run and the rest run until either count drops to one.
  function automatic rhythm_t euclid_rhythm(logic [STEP_W-1:0] beats_in,
                                            logic [STEP_W-1:0] steps_in);
    int unsigned steps, beats, onset_n, rest_n, on_t, rest_t;
    step_run_t onset_run, rest_run, rest_prev, acc;
    rhythm_t r;
    steps = steps_in;
    if (steps > STEP_LIMIT) steps = STEP_LIMIT;
    beats = beats_in;
    if (beats > steps) beats = steps;
    onset_run.bits = 64'd1;
    onset_run.len  = 1;
    onset_n        = beats;
    rest_run.bits  = 64'd0;
    rest_run.len   = 1;
    rest_n         = steps - beats;
    do begin
      on_t      = onset_n;
      rest_t    = rest_n;
      rest_prev = rest_run;
      if (on_t >= rest_t) begin
        onset_n  = rest_t;
        rest_n   = on_t - rest_t;
        rest_run = onset_run;
      end else begin
        onset_n = on_t;
        rest_n  = rest_t - on_t;
      end
      onset_run = join_runs(onset_run, rest_prev);
    end while (onset_n > 1 && rest_n > 1);
    acc.bits = 64'd0;
    acc.len  = 0;
    for (int unsigned i = 0; i < onset_n && i < 64; i++) acc = join_runs(acc, onset_run);
    for (int unsigned i = 0; i < rest_n && i < 64; i++) acc = join_runs(acc, rest_run);
    if (steps < 64) acc.bits &= (64'd1 << steps) - 64'd1;
    r.pattern   = acc.bits[PATTERN_W-1:0];
    r.length    = steps[STEP_W-1:0];
    r.req_beats = beats_in;
    r.req_steps = steps_in;
    return r;
  endfunction

  class rhythm_scoreboard;
    rhythm_t     expected_rhythms[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_rhythms.size();
    endfunction

    // Print one line per mismatch and count every one.
    task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task note_request(logic [STEP_W-1:0] beats, logic [STEP_W-1:0] steps);
      expected_rhythms.push_back(euclid_rhythm(beats, steps));
    endtask

    task check_rhythm(logic [PATTERN_W-1:0] pat, logic [STEP_W-1:0] len);
      rhythm_t want;
      if (expected_rhythms.size() == 0) begin
        report($sformatf("unexpected result pattern=%h length=%0d", pat, len));
        return;
      end
      want = expected_rhythms.pop_front();
      if (pat !== want.pattern)
        report($sformatf("beats=%0d steps=%0d pattern=%h, want %h",
                         want.req_beats, want.req_steps, pat, want.pattern));
      if (len !== want.length)
        report($sformatf("beats=%0d steps=%0d pattern_length=%0d, want %0d",
                         want.req_beats, want.req_steps, len, want.length));
    endtask
  endclass

endpackage

// ----- dv/tb.sv -----
// Top-level bench for euclidean_rhythm_generator: drives beat/step requests,
// applies random idling on both channels and checks each rhythm in order.
// Depends on erg_pkg, rhythm_sb_pkg and the generator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import erg_pkg::*;
  import rhythm_sb_pkg::*;

  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned PRESSURE_ITEMS = 20;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned TOTAL_ITEMS    = 1850;
  localparam int unsigned CALM_TAIL      = 200;
  localparam int unsigned DRAIN_CYCLES   = 60;
  // Longest quiet stretch of a correct run is the long hold plus one item's work.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned N_DIRECTED     = 23;

  // Directed requests as {beats, steps}: both fields at zero and at all ones,
  // zero steps, zero beats, beats equal to steps, beats above steps, steps above
  // the limit, and a handful of well-known rhythms.
  localparam logic [2*STEP_W-1:0] DIRECTED [N_DIRECTED] = '{
    {5'd0,  5'd0},  {5'd31, 5'd0},  {5'd0,  5'd16}, {5'd16, 5'd16},
    {5'd31, 5'd31}, {5'd0,  5'd31}, {5'd31, 5'd16}, {5'd1,  5'd1},
    {5'd0,  5'd1},  {5'd1,  5'd16}, {5'd15, 5'd16}, {5'd3,  5'd8},
    {5'd5,  5'd8},  {5'd2,  5'd5},  {5'd4,  5'd9},  {5'd5,  5'd13},
    {5'd7,  5'd12}, {5'd9,  5'd16}, {5'd7,  5'd16}, {5'd20, 5'd10},
    {5'd10, 5'd10}, {5'd13, 5'd24}, {5'd8,  5'd17}
  };

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  logic [STEP_W-1:0]    beat_count;
  logic [STEP_W-1:0]    step_count;
  logic                 rsp_valid;
  logic                 rsp_stall;
  logic [PATTERN_W-1:0] pattern;
  logic [STEP_W-1:0]    pattern_length;

  // Idling controls, set by the stimulus process and read by the others; the receiver clears long_hold.
  logic tx_gaps;
  logic rx_gaps;
  logic long_hold;

  rhythm_scoreboard sb = new();

  euclidean_rhythm_generator #(
    .MAX_STEPS(MAX_STEPS_DEF)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .beat_count    (beat_count),
    .step_count    (step_count),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .pattern       (pattern),
    .pattern_length(pattern_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Observe both channels at the rising edge: note each accepted request,
  // check each accepted rhythm against the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(beat_count, step_count);
      if (rsp_valid && !rsp_stall) sb.check_rhythm(pattern, pattern_length);
    end
  end

  // Watchdog: end the run once nothing has moved on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts while enabled; on request, hold off for one
  // long stretch so that the block backs up into its input.
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        rsp_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
        rsp_stall = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        rsp_stall = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        rsp_stall = 1'b0;
      end else begin
        rsp_stall = 1'b0;
      end
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic offer_item(input logic [STEP_W-1:0] beats, input logic [STEP_W-1:0] steps);
    @(negedge clk);
    req_valid  = 1'b1;
    beat_count = beats;
    step_count = steps;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Drop valid for a stretch whose length n gives; scramble the idle payload, which must be ignored.
  task automatic pause_sender(input int unsigned n);
    @(negedge clk);
    req_valid  = 1'b0;
    beat_count = STEP_W'($urandom);
    step_count = STEP_W'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding rhythm to come back.
  task automatic wait_drained();
    @(negedge clk);
    req_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly well-formed knob settings, with a share of clamped and saturated ones.
  task automatic pick_request(output logic [STEP_W-1:0] beats, output logic [STEP_W-1:0] steps);
    int unsigned kind;
    int unsigned s;
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      s     = $urandom_range(0, MAX_STEPS_DEF);
      steps = s[STEP_W-1:0];
      beats = STEP_W'($urandom_range(0, s));
    end else if (kind == 8) begin
      steps = STEP_W'($urandom_range(0, MAX_STEPS_DEF));
      beats = STEP_W'($urandom);
    end else begin
      steps = STEP_W'($urandom);
      beats = STEP_W'($urandom);
    end
  endtask

  initial begin
    logic [STEP_W-1:0] beats;
    logic [STEP_W-1:0] steps;
    int unsigned       n_random;
    rst        = 1'b1;
    req_valid  = 1'b0;
    beat_count = '0;
    step_count = '0;
    tx_gaps    = 1'b0;
    rx_gaps    = 1'b0;
    long_hold  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners, with the receiver stalling at random.
    rx_gaps = 1'b1;
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_item(DIRECTED[i][2*STEP_W-1:STEP_W], DIRECTED[i][STEP_W-1:0]);
    end
    wait_drained();

    // Back-pressure: hold the receiver off while requests keep coming, then let
    // the sender stand until everything has been returned.
    rx_gaps   = 1'b0;
    long_hold = 1'b1;
    for (int i = 0; i < PRESSURE_ITEMS; i++) begin
      pick_request(beats, steps);
      offer_item(beats, steps);
    end
    wait_drained();

    // Random part in blocks of fifty with fresh idling choices per block; the
    // tail runs flat out on both sides.
    n_random = TOTAL_ITEMS - N_DIRECTED - PRESSURE_ITEMS;
    for (int unsigned i = 0; i < n_random; i++) begin
      if (i >= n_random - CALM_TAIL) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end else if (i % 50 == 0) begin
        tx_gaps = ($urandom_range(0, 2) != 0);
        rx_gaps = ($urandom_range(0, 2) != 0);
      end
      pick_request(beats, steps);
      offer_item(beats, steps);
      if (tx_gaps && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 16));
      if (i % 400 == 399) wait_drained();
    end

    // Let the last rhythms out, then give the block time to show any stray one.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
